[hdl/ifss_pkg.sv]
// Package for the image format signature sniffer.
// Holds the signature table, brand words, type codes and shared types.
// No dependencies.
package ifss_pkg;

	localparam int HEAD_WINDOW = 64;
	localparam int POS_W = $clog2(HEAD_WINDOW + 1);
	localparam int SCAN_END = (HEAD_WINDOW < 64) ? HEAD_WINDOW : 64;
	localparam int NUM_SIGS = 26;
	localparam int SIG_BYTES = 12;

	typedef logic [POS_W-1:0] pos_t;

	localparam int SIG_JPG    = 0;
	localparam int SIG_PNG    = 1;
	localparam int SIG_GIF87  = 2;
	localparam int SIG_GIF89  = 3;
	localparam int SIG_BMP    = 4;
	localparam int SIG_TIFFLE = 5;
	localparam int SIG_TIFFBE = 6;
	localparam int SIG_ICO    = 7;
	localparam int SIG_RIFF   = 8;
	localparam int SIG_WEBP   = 9;
	localparam int SIG_JP2    = 10;
	localparam int SIG_JXL1   = 11;
	localparam int SIG_JXL2   = 12;
	localparam int SIG_PSD    = 13;
	localparam int SIG_PNM    = 14;
	localparam int SIG_FTYP   = 15;
	localparam int SIG_DDS    = 16;
	localparam int SIG_EXR    = 17;
	localparam int SIG_HDR1   = 18;
	localparam int SIG_HDR2   = 19;
	localparam int SIG_QOI    = 20;
	localparam int SIG_FF     = 21;
	localparam int SIG_ICNS   = 22;
	localparam int SIG_CUR    = 23;
	localparam int SIG_WMF    = 24;
	localparam int SIG_EMF    = 25;

	localparam int SIG_OFF [NUM_SIGS] = '{
		0, 0, 0, 0, 0, 0, 0, 0, 0, 8, 0, 0, 0,
		0, 0, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 40
	};
	localparam int SIG_LEN [NUM_SIGS] = '{
		3, 8, 6, 6, 2, 4, 4, 4, 4, 4, 12, 2, 12,
		4, 2, 4, 4, 4, 10, 6, 4, 8, 4, 4, 4, 4
	};
	// first byte in the top bits
	localparam logic [8*SIG_BYTES-1:0] SIG_PAT [NUM_SIGS] = '{
		96'hffd8ff00_00000000_00000000,
		96'h89504e47_0d0a1a0a_00000000,
		96'h47494638_37610000_00000000,
		96'h47494638_39610000_00000000,
		96'h424d0000_00000000_00000000,
		96'h49492a00_00000000_00000000,
		96'h4d4d002a_00000000_00000000,
		96'h00000100_00000000_00000000,
		96'h52494646_00000000_00000000,
		96'h57454250_00000000_00000000,
		96'h0000000c_6a502020_0d0a870a,
		96'hff0a0000_00000000_00000000,
		96'h0000000c_4a584c20_0d0a870a,
		96'h38425053_00000000_00000000,
		96'h50310000_00000000_00000000,
		96'h66747970_00000000_00000000,
		96'h44445320_00000000_00000000,
		96'h762f3101_00000000_00000000,
		96'h233f5241_4449414e_43450000,
		96'h233f5247_42450000_00000000,
		96'h716f6966_00000000_00000000,
		96'h66617262_66656c64_00000000,
		96'h69636e73_00000000_00000000,
		96'h00000200_00000000_00000000,
		96'hd7cdc69a_00000000_00000000,
		96'h20454d46_00000000_00000000
	};

	localparam logic [7:0] PNM_LO = 8'h31;
	localparam logic [7:0] PNM_HI = 8'h37;

	localparam logic [31:0] BRAND_JP2  = 32'h6a703220;
	localparam logic [31:0] BRAND_AVIF = 32'h61766966;
	localparam logic [31:0] BRAND_AVIS = 32'h61766973;
	localparam logic [31:0] BRAND_HEIC = 32'h68656963;
	localparam logic [31:0] BRAND_HEIX = 32'h68656978;
	localparam logic [31:0] BRAND_HEVC = 32'h68657663;
	localparam logic [31:0] BRAND_HEVX = 32'h68657678;
	localparam logic [31:0] BRAND_MIF1 = 32'h6d696631;
	localparam logic [31:0] BRAND_MSF1 = 32'h6d736631;

	localparam int BR_JP2  = 0;
	localparam int BR_AVIF = 1;
	localparam int BR_HEIC = 2;

	typedef enum logic [4:0] {
		TC_UNKNOWN = 5'd0,
		TC_JPG     = 5'd1,
		TC_PNG     = 5'd2,
		TC_GIF     = 5'd3,
		TC_BMP     = 5'd4,
		TC_TIFF    = 5'd5,
		TC_ICO     = 5'd6,
		TC_WEBP    = 5'd7,
		TC_JP2     = 5'd8,
		TC_JXL     = 5'd9,
		TC_PSD     = 5'd10,
		TC_PNM     = 5'd11,
		TC_AVIF    = 5'd12,
		TC_HEIC    = 5'd13,
		TC_DDS     = 5'd14,
		TC_EXR     = 5'd15,
		TC_HDR     = 5'd16,
		TC_QOI     = 5'd17,
		TC_FF      = 5'd18,
		TC_ICNS    = 5'd19,
		TC_CUR     = 5'd20,
		TC_WMF     = 5'd21,
		TC_EMF     = 5'd22
	} type_code_t;

	typedef struct packed {
		logic [NUM_SIGS-1:0] sig_ok;
		logic [2:0]          brand;
	} match_view_t;

endpackage

[hdl/ifss_match.sv]
// Per-file match state: byte position, last four bytes, signature flags, brands.
// Gives the post-word match view for classification. Uses ifss_pkg.
module ifss_match (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                has_byte,
	input  logic                last,
	output ifss_pkg::match_view_t view
);
	import ifss_pkg::*;

	pos_t                pos_q;
	logic [31:0]         word_q;
	logic [NUM_SIGS-1:0] alive_q;
	logic [2:0]          brand_q;

	logic                take;
	pos_t                pos_nx;
	logic [31:0]         word_nx;
	logic [NUM_SIGS-1:0] alive_nx;
	logic [NUM_SIGS-1:0] ok_nx;
	logic [2:0]          brand_nx;
	logic                scan;

	assign take    = has_byte && (pos_q < pos_t'(HEAD_WINDOW));
	assign pos_nx  = take ? pos_q + pos_t'(1) : pos_q;
	assign word_nx = {word_q[23:0], data_byte};
	assign scan    = take && (pos_nx[1:0] == 2'b00) && (pos_nx >= pos_t'(12))
		&& (pos_nx <= pos_t'(SCAN_END));

	always_comb begin
		pos_t       rel;
		logic [3:0] idx;
		logic       in_rng;
		logic       hit;
		logic [7:0] expb;
		rel = '0;
		idx = '0;
		in_rng = 1'b0;
		hit = 1'b0;
		expb = '0;
		for (int i = 0; i < NUM_SIGS; i++) begin
			rel = pos_q - pos_t'(SIG_OFF[i]);
			idx = rel[3:0];
			in_rng = (pos_q >= pos_t'(SIG_OFF[i]))
				&& (pos_q < pos_t'(SIG_OFF[i] + SIG_LEN[i]));
			expb = SIG_PAT[i][8*(SIG_BYTES-1-int'(idx)) +: 8];
			if (i == SIG_PNM && pos_q == pos_t'(1)) begin
				hit = (data_byte >= PNM_LO) && (data_byte <= PNM_HI);
			end else begin
				hit = (data_byte == expb);
			end
			alive_nx[i] = alive_q[i] && !(take && in_rng && !hit);
			ok_nx[i] = alive_nx[i] && (pos_nx >= pos_t'(SIG_OFF[i] + SIG_LEN[i]));
		end
	end

	always_comb begin
		brand_nx = brand_q;
		if (scan) begin
			if (word_nx == BRAND_JP2)
				brand_nx[BR_JP2] = 1'b1;
			if (word_nx == BRAND_AVIF || word_nx == BRAND_AVIS)
				brand_nx[BR_AVIF] = 1'b1;
			if (word_nx == BRAND_HEIC || word_nx == BRAND_HEIX ||
			    word_nx == BRAND_HEVC || word_nx == BRAND_HEVX ||
			    word_nx == BRAND_MIF1 || word_nx == BRAND_MSF1)
				brand_nx[BR_HEIC] = 1'b1;
		end
	end

	assign view = {ok_nx, brand_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			word_q  <= '0;
			alive_q <= '1;
			brand_q <= '0;
		end else if (step) begin
			if (last) begin
				pos_q   <= '0;
				word_q  <= '0;
				alive_q <= '1;
				brand_q <= '0;
			end else if (take) begin
				pos_q   <= pos_nx;
				word_q  <= word_nx;
				alive_q <= alive_nx;
				brand_q <= brand_nx;
			end
		end
	end

endmodule

[hdl/ifss_classify.sv]
// Priority encoder from the match view to the image type code.
// Uses ifss_pkg.
module ifss_classify (
	input  ifss_pkg::match_view_t view,
	input  logic                  has_byte,
	output ifss_pkg::type_code_t  type_code
);
	import ifss_pkg::*;

	logic                ftyp;
	logic [NUM_SIGS-1:0] ok;

	assign ok   = view.sig_ok;
	assign ftyp = ok[SIG_FTYP];

	always_comb begin
		priority if (!has_byte)                                 type_code = TC_UNKNOWN;
		else if (ok[SIG_JPG])                                   type_code = TC_JPG;
		else if (ok[SIG_PNG])                                   type_code = TC_PNG;
		else if (ok[SIG_GIF87] || ok[SIG_GIF89])                type_code = TC_GIF;
		else if (ok[SIG_BMP])                                   type_code = TC_BMP;
		else if (ok[SIG_TIFFLE] || ok[SIG_TIFFBE])              type_code = TC_TIFF;
		else if (ok[SIG_ICO])                                   type_code = TC_ICO;
		else if (ok[SIG_RIFF] && ok[SIG_WEBP])                  type_code = TC_WEBP;
		else if (ok[SIG_JP2] || (ftyp && view.brand[BR_JP2]))   type_code = TC_JP2;
		else if (ok[SIG_JXL1] || ok[SIG_JXL2])                  type_code = TC_JXL;
		else if (ok[SIG_PSD])                                   type_code = TC_PSD;
		else if (ok[SIG_PNM])                                   type_code = TC_PNM;
		else if (ftyp && view.brand[BR_AVIF])                   type_code = TC_AVIF;
		else if (ftyp && view.brand[BR_HEIC])                   type_code = TC_HEIC;
		else if (ok[SIG_DDS])                                   type_code = TC_DDS;
		else if (ok[SIG_EXR])                                   type_code = TC_EXR;
		else if (ok[SIG_HDR1] || ok[SIG_HDR2])                  type_code = TC_HDR;
		else if (ok[SIG_QOI])                                   type_code = TC_QOI;
		else if (ok[SIG_FF])                                    type_code = TC_FF;
		else if (ok[SIG_ICNS])                                  type_code = TC_ICNS;
		else if (ok[SIG_CUR])                                   type_code = TC_CUR;
		else if (ok[SIG_WMF])                                   type_code = TC_WMF;
		else if (ok[SIG_EMF])                                   type_code = TC_EMF;
		else                                                    type_code = TC_UNKNOWN;
	end

endmodule

[hdl/image_format_signature_sniffer_core.sv]
// Top level of the image format signature sniffer.
// Input word register, match state, classifier and result register.
// Uses ifss_pkg, ifss_match, ifss_classify.
//
// Takes one file byte per cycle while byte_stall is low. A word is held in the input register
// while the match state is updated from it; the type code of a file is loaded into the
// result register when its final word leaves the input register. The byte input
// stalls only when a final word is waiting and the previous type code has not been
// taken. Only the first HEAD_WINDOW bytes of a file are examined.
module image_format_signature_sniffer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       has_byte,
	input  logic       last,
	output logic       type_valid,
	input  logic       type_stall,
	output logic [4:0] type_code
);
	import ifss_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_byte_s1;
	logic        has_byte_s1;
	logic        last_s1;
	logic        type_valid_q;
	logic [4:0]  type_code_q;

	logic        out_free;
	logic        go;
	logic        accept;
	match_view_t view;
	type_code_t  code;

	assign out_free   = !type_valid_q || !type_stall;
	assign go         = valid_s1 && (!last_s1 || out_free);
	assign byte_stall = valid_s1 && !go;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_byte_s1 <= data_byte;
			has_byte_s1  <= has_byte;
			last_s1      <= last;
		end
	end

	ifss_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (go),
		.data_byte (data_byte_s1),
		.has_byte  (has_byte_s1),
		.last      (last_s1),
		.view      (view)
	);

	ifss_classify u_classify (
		.view      (view),
		.has_byte  (has_byte_s1),
		.type_code (code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_valid_q <= 1'b0;
		end else if (go && last_s1) begin
			type_valid_q <= 1'b1;
		end else if (!type_stall) begin
			type_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			type_code_q <= 5'(code);
		end
	end

	assign type_valid = type_valid_q;
	assign type_code  = type_code_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && last_s1 && type_valid_q && type_stall))
		else $error("byte input stalled without a held result");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		type_valid |-> (type_code <= 5'(TC_EMF)))
		else $error("type code out of range");

	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(go && last_s1 && !has_byte_s1) |=> (type_valid && type_code == 5'(TC_UNKNOWN)))
		else $error("end marker without byte must give unknown");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(go && last_s1) |=> type_valid)
		else $error("final word did not produce a result");

endmodule

[bench/tb_image_format_signature_sniffer_core.sv]
// Testbench for image_format_signature_sniffer_core: streams whole files and checks type codes.
// Uses its own signature table and classifier, with random input gaps and random result-side stalls.
// Depends on ifss_pkg (type codes, signature indexes, HEAD_WINDOW) and the core RTL.
`timescale 1ns / 100ps

module tb_image_format_signature_sniffer_core;
	import ifss_pkg::*;

	localparam int ITEM_TARGET = 1150;
	localparam int MAGIC_COUNT = 26;
	localparam int BRAND_SCAN_LIMIT = (HEAD_WINDOW < 64) ? HEAD_WINDOW : 64;
	localparam logic [7:0] DIGIT_LO = 8'h31;
	localparam logic [7:0] DIGIT_HI = 8'h37;

	localparam int MAGIC_OFF [MAGIC_COUNT] = '{
		0, 0, 0, 0, 0, 0, 0, 0, 0, 8, 0, 0, 0,
		0, 0, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 40
	};
	localparam int MAGIC_LEN [MAGIC_COUNT] = '{
		3, 8, 6, 6, 2, 4, 4, 4, 4, 4, 12, 2, 12,
		4, 2, 4, 4, 4, 10, 6, 4, 8, 4, 4, 4, 4
	};
	localparam logic [95:0] MAGIC_PAT [MAGIC_COUNT] = '{
		{24'hffd8ff, 72'h0},
		{8'h89, "PNG", 32'h0d0a1a0a, 32'h0},
		{"GIF87a", 48'h0},
		{"GIF89a", 48'h0},
		{"BM", 80'h0},
		{"II*", 8'h00, 64'h0},
		{"MM", 8'h00, "*", 64'h0},
		{32'h00000100, 64'h0},
		{"RIFF", 64'h0},
		{"WEBP", 64'h0},
		{32'h0000000c, "jP  ", 32'h0d0a870a},
		{16'hff0a, 80'h0},
		{32'h0000000c, "JXL ", 32'h0d0a870a},
		{"8BPS", 64'h0},
		{"P1", 80'h0},
		{"ftyp", 64'h0},
		{"DDS ", 64'h0},
		{32'h762f3101, 64'h0},
		{"#?RADIANCE", 16'h0},
		{"#?RGBE", 48'h0},
		{"qoif", 64'h0},
		{"farbfeld", 32'h0},
		{"icns", 64'h0},
		{32'h00000200, 64'h0},
		{32'hd7cdc69a, 64'h0},
		{" EMF", 64'h0}
	};

	localparam logic [31:0] W_JP2  = "jp2 ";
	localparam logic [31:0] W_AVIF = "avif";
	localparam logic [31:0] W_AVIS = "avis";
	localparam logic [31:0] W_HEIC = "heic";
	localparam logic [31:0] W_HEIX = "heix";
	localparam logic [31:0] W_HEVC = "hevc";
	localparam logic [31:0] W_HEVX = "hevx";
	localparam logic [31:0] W_MIF1 = "mif1";
	localparam logic [31:0] W_MSF1 = "msf1";
	localparam logic [31:0] BRAND_WORDS [9] = '{
		W_JP2, W_AVIF, W_AVIS, W_HEIC, W_HEIX, W_HEVC, W_HEVX, W_MIF1, W_MSF1
	};

	typedef enum int {GAP_NONE, GAP_LIGHT, GAP_HEAVY} gap_mode_e;

	class format_scoreboard;
		int pos;
		logic [31:0] tail_word;
		logic [MAGIC_COUNT-1:0] alive;
		logic [2:0] brands;
		type_code_t expected_codes[$];
		int mismatches;

		function new();
			mismatches = 0;
			clear_file();
		endfunction

		function void clear_file();
			pos = 0;
			tail_word = '0;
			alive = '1;
			brands = '0;
		endfunction

		function bit complete(int s);
			return alive[s] && pos >= MAGIC_OFF[s] + MAGIC_LEN[s];
		endfunction

		function void absorb_byte(logic [7:0] b);
			logic [95:0] pat;
			int k;
			bit hit;
			for (int s = 0; s < MAGIC_COUNT; s++) begin
				k = pos - MAGIC_OFF[s];
				if (k >= 0 && k < MAGIC_LEN[s]) begin
					pat = MAGIC_PAT[s];
					if (s == SIG_PNM && k == 1)
						hit = (b >= DIGIT_LO && b <= DIGIT_HI);
					else
						hit = (b == pat[95 - 8*k -: 8]);
					if (!hit)
						alive[s] = 1'b0;
				end
			end
			tail_word = {tail_word[23:0], b};
			pos++;
			if (pos % 4 == 0 && pos >= 12 && pos <= BRAND_SCAN_LIMIT) begin
				if (tail_word == W_JP2)
					brands[0] = 1'b1;
				if (tail_word == W_AVIF || tail_word == W_AVIS)
					brands[1] = 1'b1;
				if (tail_word == W_HEIC || tail_word == W_HEIX || tail_word == W_HEVC ||
				    tail_word == W_HEVX || tail_word == W_MIF1 || tail_word == W_MSF1)
					brands[2] = 1'b1;
			end
		endfunction

		function type_code_t classify_file();
			bit ftyp;
			ftyp = complete(SIG_FTYP);
			if (complete(SIG_JPG)) return TC_JPG;
			if (complete(SIG_PNG)) return TC_PNG;
			if (complete(SIG_GIF87) || complete(SIG_GIF89)) return TC_GIF;
			if (complete(SIG_BMP)) return TC_BMP;
			if (complete(SIG_TIFFLE) || complete(SIG_TIFFBE)) return TC_TIFF;
			if (complete(SIG_ICO)) return TC_ICO;
			if (complete(SIG_RIFF) && complete(SIG_WEBP)) return TC_WEBP;
			if (complete(SIG_JP2) || (ftyp && brands[0])) return TC_JP2;
			if (complete(SIG_JXL1) || complete(SIG_JXL2)) return TC_JXL;
			if (complete(SIG_PSD)) return TC_PSD;
			if (complete(SIG_PNM)) return TC_PNM;
			if (ftyp && brands[1]) return TC_AVIF;
			if (ftyp && brands[2]) return TC_HEIC;
			if (complete(SIG_DDS)) return TC_DDS;
			if (complete(SIG_EXR)) return TC_EXR;
			if (complete(SIG_HDR1) || complete(SIG_HDR2)) return TC_HDR;
			if (complete(SIG_QOI)) return TC_QOI;
			if (complete(SIG_FF)) return TC_FF;
			if (complete(SIG_ICNS)) return TC_ICNS;
			if (complete(SIG_CUR)) return TC_CUR;
			if (complete(SIG_WMF)) return TC_WMF;
			if (complete(SIG_EMF)) return TC_EMF;
			return TC_UNKNOWN;
		endfunction

		function void note_word(logic [7:0] b, logic has, logic fin);
			if (has && pos < HEAD_WINDOW)
				absorb_byte(b);
			if (fin) begin
				expected_codes.push_back(has ? classify_file() : TC_UNKNOWN);
				clear_file();
			end
		endfunction

		function void report(string what, int exp_code, logic [4:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%t mismatch: %s expected %0d got %0d", $realtime, what, exp_code, got);
		endfunction

		function void check_code(logic [4:0] got);
			type_code_t exp_code;
			if (expected_codes.size() == 0) begin
				report("unexpected type code,", -1, got);
			end else begin
				exp_code = expected_codes.pop_front();
				if (got !== exp_code)
					report("type_code", exp_code, got);
			end
		endfunction

		function int pending();
			return expected_codes.size();
		endfunction

		function bit failed();
			if (expected_codes.size() != 0)
				$display("%0d type codes never arrived", expected_codes.size());
			return mismatches != 0 || expected_codes.size() != 0;
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;
	logic       type_valid;
	logic       type_stall;
	logic [4:0] type_code;

	format_scoreboard sb = new();
	gap_mode_e gap_mode = GAP_NONE;
	int words_sent = 0;
	logic [7:0] file_buf[$];

	image_format_signature_sniffer_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.has_byte   (has_byte),
		.last       (last),
		.type_valid (type_valid),
		.type_stall (type_stall),
		.type_code  (type_code)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("** image_format_signature_sniffer_core: FAILED **");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		case (gap_mode)
			GAP_NONE: return 0;
			GAP_LIGHT: begin
				if (r < 75) return 0;
				if (r < 98) return $urandom_range(1, 3);
				return $urandom_range(10, 40);
			end
			default: begin
				if (r < 40) return 0;
				if (r < 92) return $urandom_range(1, 4);
				return $urandom_range(10, 60);
			end
		endcase
	endfunction

	// result side back-pressure
	initial begin
		int n;
		type_stall = 1'b0;
		forever begin
			n = pick_gap();
			@(negedge clk);
			if (n > 0) begin
				type_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			type_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && type_valid && !type_stall)
			sb.check_code(type_code);
	end

	task automatic send_word(input logic [7:0] b, input logic has, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			byte_valid <= 1'b0;
			data_byte <= 8'($urandom);
			has_byte <= 1'($urandom);
			last <= 1'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		byte_valid <= 1'b1;
		data_byte <= b;
		has_byte <= has;
		last <= fin;
		do @(posedge clk); while (byte_stall);
		sb.note_word(b, has, fin);
		if (has || fin)
			words_sent++;
	endtask

	task automatic send_file(input bit with_marker, input int idle_pct);
		for (int i = 0; i < file_buf.size(); i++) begin
			if ($urandom_range(0, 99) < idle_pct)
				send_word(8'($urandom), 1'b0, 1'b0);
			send_word(file_buf[i], 1'b1, !with_marker && i == file_buf.size() - 1);
		end
		if (with_marker)
			send_word(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic fill_random(input int len);
		file_buf = {};
		repeat (len) file_buf.push_back(8'($urandom));
	endtask

	task automatic put_word(input int at, input logic [31:0] w);
		for (int k = 0; k < 4; k++)
			if (at + k < file_buf.size())
				file_buf[at + k] = w[31 - 8*k -: 8];
	endtask

	task automatic put_magic(input int s);
		logic [95:0] pat;
		int at;
		pat = MAGIC_PAT[s];
		for (int k = 0; k < MAGIC_LEN[s]; k++) begin
			at = MAGIC_OFF[s] + k;
			if (at < file_buf.size()) begin
				if (s == SIG_PNM && k == 1)
					file_buf[at] = 8'($urandom_range(DIGIT_LO, DIGIT_HI));
				else
					file_buf[at] = pat[95 - 8*k -: 8];
			end
		end
	endtask

	function automatic logic [31:0] pick_brand();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return BRAND_WORDS[$urandom_range(0, 8)];
	endfunction

	task automatic build_ftyp_file(input int len);
		fill_random(len);
		put_word(0, {24'h0, 8'($urandom_range(8, 40))});
		put_magic(SIG_FTYP);
		for (int at = 8; at + 4 <= len; at += 4)
			if ($urandom_range(0, 2) == 0)
				put_word(at, pick_brand());
		if ($urandom_range(0, 5) == 0)
			put_word($urandom_range(9, 58), pick_brand());
	endtask

	task automatic build_signature_file(input int s, input int len, input bit corrupt);
		int need;
		int k;
		need = MAGIC_OFF[s] + MAGIC_LEN[s];
		fill_random(len);
		if ($urandom_range(0, 4) == 0) begin
			put_magic(SIG_FTYP);
			put_word(4 * $urandom_range(2, 15), pick_brand());
		end
		if ($urandom_range(0, 5) == 0)
			put_magic(SIG_EMF);
		if (s == SIG_WEBP && $urandom_range(0, 5) != 0)
			put_magic(SIG_RIFF);
		put_magic(s);
		if (corrupt) begin
			k = $urandom_range(MAGIC_OFF[s], need - 1);
			if (k < len)
				file_buf[k] = file_buf[k] ^ 8'($urandom_range(1, 255));
		end
	endtask

	task automatic build_random_file();
		int kind;
		int s;
		int need;
		kind = $urandom_range(0, 99);
		s = $urandom_range(0, MAGIC_COUNT - 1);
		need = MAGIC_OFF[s] + MAGIC_LEN[s];
		if (kind < 55)
			build_signature_file(s, need + $urandom_range(0, 6), 1'b0);
		else if (kind < 72)
			build_ftyp_file(4 * $urandom_range(3, 17) + (($urandom_range(0, 3) == 0) ?
				$urandom_range(1, 3) : 0));
		else if (kind < 80)
			build_signature_file(s, need + $urandom_range(0, 4), 1'b1);
		else if (kind < 86)
			build_signature_file(s, $urandom_range(1, need - 1), 1'b0);
		else if (kind < 93)
			fill_random($urandom_range(1, 30));
		else if ($urandom_range(0, 1) == 0)
			build_ftyp_file(HEAD_WINDOW + $urandom_range(0, 20));
		else
			build_signature_file(s, HEAD_WINDOW + $urandom_range(0, 20), 1'b0);
	endtask

	initial begin
		int files;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		data_byte = 8'h00;
		has_byte = 1'b0;
		last = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: bare end marker, idle word, short and boundary cases
		send_word(8'hff, 1'b0, 1'b1);
		send_word(8'h5a, 1'b0, 1'b0);
		file_buf = {8'hff, 8'hd8, 8'hff};
		send_file(1'b0, 0);
		file_buf = {8'hff, 8'h0a};
		send_file(1'b0, 0);
		file_buf = {8'h50, DIGIT_LO};
		send_file(1'b0, 0);
		file_buf = {8'h50, DIGIT_HI};
		send_file(1'b0, 0);
		file_buf = {8'h50, 8'h38};
		send_file(1'b0, 0);
		file_buf = {8'h42, 8'h4d};
		send_file(1'b1, 0);
		file_buf = {8'h89, 8'h50, 8'h4e, 8'h47};
		send_file(1'b0, 0);
		file_buf = {8'h00, 8'hff};
		send_file(1'b0, 0);

		files = 0;
		while (words_sent < ITEM_TARGET) begin
			if (files % 8 == 0)
				gap_mode = gap_mode_e'($urandom_range(0, 2));
			build_random_file();
			send_file($urandom_range(0, 9) == 0, ($urandom_range(0, 2) == 0) ? 6 : 0);
			files++;
		end
		@(negedge clk);
		byte_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.failed())
			$display("** image_format_signature_sniffer_core: FAILED **");
		else
			$display("** image_format_signature_sniffer_core: PASSED **");
		$finish;
	end

endmodule
